// File: rtl/tpl_pkg.sv
// ----------------------------------------------------------------------------
// tpl_pkg: shared types and constants of the true-peak limiter
// Holds sizes, payload structs, controller/datapath command and status
// groups, register map codes and the controller state encoding.
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int BLOCK_SAMPLES = 64;
  localparam int MAX_CHANNELS  = 8;
  localparam int SAMPLE_W      = 24;

  localparam int BUF_AW    = $clog2(BLOCK_SAMPLES);
  localparam int FILL_W    = $clog2(BLOCK_SAMPLES + 1);
  localparam int CH_W      = $clog2(MAX_CHANNELS);
  localparam int GAIN_W    = 17;
  localparam int CNT_W     = 4;
  localparam int REC_W     = 24;
  localparam int REC_PW    = (GAIN_W - 1) + REC_W;
  localparam int PROD_W    = (SAMPLE_W + 1) + (GAIN_W + 1);
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = $clog2(DIV_STEPS);
  localparam int PAD_W     = 4;
  localparam int DATA_W    = 32;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);

  // Register map (word index within the APB window)
  localparam logic [1:0] REG_CEILING  = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_RECOVERY = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end;
  } tpl_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [GAIN_W-1:0]          block_gain;
    logic                       last_out;
  } tpl_result_t;

  typedef struct packed {
    logic [GAIN_W-1:0] ceiling_gain;
    logic [CNT_W-1:0]  channel_count;
    logic [REC_W-1:0]  recovery_factor;
  } tpl_cfg_t;

  typedef struct packed {
    logic load;
    logic peak;
    logic div_start;
    logic req_load;
    logic gain;
    logic emit;
    logic scale_mul;
    logic scale_wr;
    logic close;
  } tpl_cmd_t;

  typedef struct packed {
    logic block_done;
    logic div_done;
    logic emit_last;
    logic pipe_empty;
    logic scale_last;
  } tpl_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEAK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_GAIN,
    ST_EMIT,
    ST_DRAIN,
    ST_SCALE_MUL,
    ST_SCALE_WR
  } tpl_state_e;

endpackage

// File: rtl/tpl_div.sv
// ----------------------------------------------------------------------------
// tpl_div: restoring divider for the required gain
// Computes (dividend_i << 16) / divisor_i, one quotient bit per cycle.
// The quotient is valid when done_o pulses.
// ----------------------------------------------------------------------------
module tpl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tpl_pkg::SAMPLE_W-2:0]  dividend_i,
  input  logic [tpl_pkg::SAMPLE_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [tpl_pkg::DIV_STEPS-1:0] quot_o
);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [tpl_pkg::DIV_CW-1:0]    cnt_q, cnt_d;
  logic [tpl_pkg::SAMPLE_W-1:0]  rem_q, rem_d;
  logic [tpl_pkg::DIV_STEPS-1:0] quot_q, quot_d;
  logic [tpl_pkg::SAMPLE_W:0]    trial;
  logic                          fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, dividend_i};
      quot_d = '0;
    end else if (run_q) begin
      // shift in a zero dividend bit, subtract when the divisor fits
      rem_d  = fits ? tpl_pkg::SAMPLE_W'(trial - {1'b0, divisor_i})
                    : trial[tpl_pkg::SAMPLE_W-1:0];
      quot_d = {quot_q[tpl_pkg::DIV_STEPS-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == tpl_pkg::DIV_CW'(tpl_pkg::DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/tpl_datapath.sv
// ----------------------------------------------------------------------------
// tpl_datapath: sample buffer, peak tracker, gain logic and scaler
// Executes the controller's commands and reports status back; drives the
// result strobe and payload from its output register.
// ----------------------------------------------------------------------------
module tpl_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tpl_pkg::tpl_cfg_t     cfg_i,
  input  tpl_pkg::tpl_item_t    item_i,
  input  tpl_pkg::tpl_cmd_t     cmd_i,
  output tpl_pkg::tpl_stat_t    stat_o,
  output tpl_pkg::tpl_result_t  result_o,
  output logic                  result_valid_o
);

  localparam int SW = tpl_pkg::SAMPLE_W;
  localparam int NW = SW + 3;
  localparam int GW = tpl_pkg::GAIN_W;
  localparam int CS = SW - 2 - 16;

  function automatic logic [NW-2:0] mag(input logic signed [NW-1:0] v);
    logic [NW-1:0] a;
    a = v[NW-1] ? NW'(-v) : NW'(v);
    return a[NW-2:0];
  endfunction

  // storage
  logic signed [SW-1:0] buf_mem [tpl_pkg::BLOCK_SAMPLES];
  logic signed [SW-1:0] prev_q [tpl_pkg::MAX_CHANNELS];

  logic [tpl_pkg::FILL_W-1:0] fill_q;
  logic [tpl_pkg::CH_W-1:0]   ch_q;
  logic                       pv_q;
  logic [SW-1:0]              peak_q;
  logic [GW-1:0]              applied_q;
  logic signed [SW-1:0]       x_q, p_q;
  logic                       pvs_q, end_q;
  logic [GW-1:0]              req_q, gain_q;
  logic [tpl_pkg::REC_PW-1:0] rec_prod_q;
  logic [tpl_pkg::BUF_AW-1:0] rd_cnt_q;
  logic signed [SW-1:0]       rd_data_q;
  logic                       v1_q, l1_q, v2_q, l2_q;
  logic signed [tpl_pkg::PROD_W-1:0] prod_q;
  logic [tpl_pkg::CH_W-1:0]   sc_q;
  tpl_pkg::tpl_result_t       result_q;
  logic                       result_valid_q;

  // channel selection
  logic [tpl_pkg::CNT_W-1:0] cnt_eff, ch_nxt;
  logic [tpl_pkg::CH_W-1:0]  ch_cur;
  logic                      wrap;

  always_comb begin
    if (cfg_i.channel_count == '0) begin
      cnt_eff = tpl_pkg::CNT_W'(1);
    end else if (cfg_i.channel_count > tpl_pkg::CNT_W'(tpl_pkg::MAX_CHANNELS)) begin
      cnt_eff = tpl_pkg::CNT_W'(tpl_pkg::MAX_CHANNELS);
    end else begin
      cnt_eff = cfg_i.channel_count;
    end
  end

  assign ch_cur = ({1'b0, ch_q} < cnt_eff) ? ch_q : '0;
  assign ch_nxt = {1'b0, ch_cur} + 1'b1;
  assign wrap   = ch_nxt >= cnt_eff;

  // peak candidates: |x| and the three quarter-step interpolations
  logic signed [NW-1:0] p_ext, x_ext, n1, n2, n3;
  logic [SW-1:0]        m0, m1, m2, m3, mx_a, mx_b, mx;

  assign p_ext = NW'(p_q);
  assign x_ext = NW'(x_q);
  assign n1    = (p_ext <<< 1) + p_ext + x_ext;
  assign n2    = (p_ext + x_ext) <<< 1;
  assign n3    = p_ext + (x_ext <<< 1) + x_ext;

  always_comb begin
    logic [NW-2:0] a0, a1, a2, a3;
    a0   = mag(x_ext);
    a1   = mag(n1);
    a2   = mag(n2);
    a3   = mag(n3);
    m0   = a0[SW-1:0];
    m1   = pvs_q ? a1[NW-2:2] : '0;
    m2   = pvs_q ? a2[NW-2:2] : '0;
    m3   = pvs_q ? a3[NW-2:2] : '0;
    mx_a = (m0 > m1) ? m0 : m1;
    mx_b = (m2 > m3) ? m2 : m3;
    mx   = (mx_a > mx_b) ? mx_a : mx_b;
  end

  // required gain
  logic [GW-1:0]                  ceil_eff;
  logic                           peak_small;
  logic                           div_done;
  logic [tpl_pkg::DIV_STEPS-1:0]  quot;

  assign ceil_eff   = (cfg_i.ceiling_gain > tpl_pkg::UNITY) ? tpl_pkg::UNITY
                                                            : cfg_i.ceiling_gain;
  assign peak_small = peak_q <= {1'b0, ceil_eff, CS'(0)};

  tpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({ceil_eff, CS'(0)}),
    .divisor_i  (peak_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // recovery bound and final gain
  logic [GW-1:0] rec_lim, rec, gain_d;

  always_comb begin
    rec_lim = (rec_prod_q[tpl_pkg::REC_PW-1:16] > tpl_pkg::REC_W'(tpl_pkg::UNITY))
            ? tpl_pkg::UNITY : rec_prod_q[16 +: GW];
    rec     = applied_q[GW-1] ? applied_q : rec_lim;
    if (req_q >= applied_q) begin
      gain_d = (req_q < rec) ? req_q : rec;
    end else begin
      gain_d = req_q;
    end
  end

  // shared scaler: product, then truncate toward zero
  logic signed [SW-1:0]             mul_a;
  logic signed [tpl_pkg::PROD_W-1:0] rnd;
  logic signed [SW-1:0]             scaled;

  assign mul_a  = cmd_i.scale_mul ? prev_q[0] : rd_data_q;
  assign rnd    = prod_q + (prod_q[tpl_pkg::PROD_W-1] ? tpl_pkg::PROD_W'(65535)
                                                      : tpl_pkg::PROD_W'(0));
  assign scaled = rnd[16 +: SW];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q         <= '0;
      ch_q           <= '0;
      pv_q           <= 1'b0;
      peak_q         <= '0;
      applied_q      <= tpl_pkg::UNITY;
      for (int i = 0; i < tpl_pkg::MAX_CHANNELS; i++) prev_q[i] <= '0;
      rd_cnt_q       <= '0;
      sc_q           <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      v1_q           <= cmd_i.emit;
      v2_q           <= v1_q;
      result_valid_q <= v2_q;
      if (cmd_i.load) begin
        fill_q         <= fill_q + 1'b1;
        prev_q[ch_cur] <= item_i.sample_in;
        ch_q           <= wrap ? '0 : ch_nxt[tpl_pkg::CH_W-1:0];
        if (wrap) pv_q <= 1'b1;
      end
      if (cmd_i.peak && (mx > peak_q)) peak_q <= mx;
      if (cmd_i.gain) rd_cnt_q <= '0;
      if (cmd_i.emit) rd_cnt_q <= rd_cnt_q + 1'b1;
      if (cmd_i.scale_wr) begin
        // rotate the history so every entry passes the scaler once
        for (int i = 0; i < tpl_pkg::MAX_CHANNELS - 1; i++) prev_q[i] <= prev_q[i+1];
        prev_q[tpl_pkg::MAX_CHANNELS-1] <= scaled;
        sc_q <= sc_q + 1'b1;
      end
      if (cmd_i.close) begin
        fill_q    <= '0;
        ch_q      <= '0;
        pv_q      <= 1'b1;
        peak_q    <= '0;
        applied_q <= gain_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      buf_mem[fill_q[tpl_pkg::BUF_AW-1:0]] <= item_i.sample_in;
      x_q   <= item_i.sample_in;
      p_q   <= prev_q[ch_cur];
      pvs_q <= pv_q;
      end_q <= item_i.block_end;
    end
    if (cmd_i.emit) begin
      rd_data_q <= buf_mem[rd_cnt_q];
      l1_q      <= stat_o.emit_last;
    end
    if (cmd_i.div_start) begin
      rec_prod_q <= tpl_pkg::REC_PW'(applied_q[GW-2:0])
                  * tpl_pkg::REC_PW'(cfg_i.recovery_factor);
    end
    if (cmd_i.req_load)  req_q <= peak_small ? tpl_pkg::UNITY : {1'b0, quot};
    if (cmd_i.gain)      gain_q <= gain_d;
    if (v1_q || cmd_i.scale_mul) begin
      prod_q <= tpl_pkg::PROD_W'(mul_a) * tpl_pkg::PROD_W'($signed({1'b0, gain_q}));
    end
    l2_q <= l1_q;
    if (v2_q) begin
      result_q.sample_out <= scaled;
      result_q.block_gain <= gain_q;
      result_q.last_out   <= l2_q;
    end
  end

  assign stat_o.block_done = end_q || (fill_q == tpl_pkg::FILL_W'(tpl_pkg::BLOCK_SAMPLES));
  assign stat_o.div_done   = div_done;
  assign stat_o.emit_last  = ({1'b0, rd_cnt_q} == (fill_q - 1'b1));
  assign stat_o.pipe_empty = !v1_q && !v2_q;
  assign stat_o.scale_last = sc_q == tpl_pkg::CH_W'(tpl_pkg::MAX_CHANNELS - 1);

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule

// File: rtl/tpl_ctrl.sv
// ----------------------------------------------------------------------------
// tpl_ctrl: sequencer of the true-peak limiter
// Steps through load, peak update, gain computation, emission and
// history scaling by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module tpl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tpl_pkg::tpl_stat_t stat_i,
  output tpl_pkg::tpl_cmd_t  cmd_o,
  output logic               busy_o
);

  tpl_pkg::tpl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      tpl_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = tpl_pkg::ST_PEAK;
        end
      end
      tpl_pkg::ST_PEAK: begin
        cmd_o.peak = 1'b1;
        state_d    = stat_i.block_done ? tpl_pkg::ST_DIV_GO : tpl_pkg::ST_IDLE;
      end
      tpl_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = tpl_pkg::ST_DIV_WAIT;
      end
      tpl_pkg::ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.req_load = 1'b1;
          state_d        = tpl_pkg::ST_GAIN;
        end
      end
      tpl_pkg::ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = tpl_pkg::ST_EMIT;
      end
      tpl_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_last) state_d = tpl_pkg::ST_DRAIN;
      end
      tpl_pkg::ST_DRAIN: begin
        if (stat_i.pipe_empty) state_d = tpl_pkg::ST_SCALE_MUL;
      end
      tpl_pkg::ST_SCALE_MUL: begin
        cmd_o.scale_mul = 1'b1;
        state_d         = tpl_pkg::ST_SCALE_WR;
      end
      tpl_pkg::ST_SCALE_WR: begin
        cmd_o.scale_wr = 1'b1;
        if (stat_i.scale_last) begin
          cmd_o.close = 1'b1;
          state_d     = tpl_pkg::ST_IDLE;
        end else begin
          state_d = tpl_pkg::ST_SCALE_MUL;
        end
      end
      default: begin
        state_d = tpl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/block_true_peak_limiter.sv
// ----------------------------------------------------------------------------
// block_true_peak_limiter: block-based true-peak limiter
// Buffers interleaved Q1.22 samples, tracks a quarter-step true-peak
// estimate and emits each block scaled by a single limited gain.
// ----------------------------------------------------------------------------
// Loading: a sample is accepted, then the peak is updated; busy drops after
//   unless the block is complete. Block end: divider start, serial divide,
//   request load and gain step, then one issue per sample through the read,
//   product and output registers; history scaling then passes all 8 entries.
// Reset: config registers take defaults, applied gain unity, the block is empty; the
//   receiver cannot stall, each result strobes result_valid_o for one cycle.
module block_true_peak_limiter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpl_pkg::PAD_W-1:0]         paddr,
  input  logic [tpl_pkg::DATA_W-1:0]        pwdata,
  output logic [tpl_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  // sample input
  input  logic                              start,
  output logic                              busy,
  input  tpl_pkg::tpl_item_t                item_i,
  // results
  output tpl_pkg::tpl_result_t              result_o,
  output logic                              result_valid_o
);

  // --------------------------------------------------------------------------
  // Configuration registers: written on the APB access phase, read anytime.
  // --------------------------------------------------------------------------
  logic [tpl_pkg::GAIN_W-1:0] ceiling_q;
  logic [tpl_pkg::CNT_W-1:0]  channels_q;
  logic [tpl_pkg::REC_W-1:0]  recovery_q;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q  <= tpl_pkg::UNITY;
      channels_q <= tpl_pkg::CNT_W'(2);
      recovery_q <= tpl_pkg::REC_W'(165100);
    end else if (wr_en) begin
      unique case (reg_idx)
        tpl_pkg::REG_CEILING:  ceiling_q  <= pwdata[tpl_pkg::GAIN_W-1:0];
        tpl_pkg::REG_CHANNELS: channels_q <= pwdata[tpl_pkg::CNT_W-1:0];
        tpl_pkg::REG_RECOVERY: recovery_q <= pwdata[tpl_pkg::REC_W-1:0];
        default: begin
          // drop writes outside the register map
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tpl_pkg::REG_CEILING:  prdata = tpl_pkg::DATA_W'(ceiling_q);
      tpl_pkg::REG_CHANNELS: prdata = tpl_pkg::DATA_W'(channels_q);
      tpl_pkg::REG_RECOVERY: prdata = tpl_pkg::DATA_W'(recovery_q);
      default:               prdata = '0;
    endcase
  end

  tpl_pkg::tpl_cfg_t cfg;

  assign cfg.ceiling_gain    = ceiling_q;
  assign cfg.channel_count   = channels_q;
  assign cfg.recovery_factor = recovery_q;

  // --------------------------------------------------------------------------
  // Controller and datapath. A sample transfer happens when start is high
  // while busy is low; the controller holds busy through the peak update and
  // through the whole end-of-block sequence.
  // --------------------------------------------------------------------------
  tpl_pkg::tpl_cmd_t  cmd;
  tpl_pkg::tpl_stat_t stat;

  tpl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  tpl_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
